FILE: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros for the encryptor RTL. Each one checks on the rising edge
// of clk and is switched off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that an expression is true at every clock edge.
`define ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error(msg);

// Checks that a consequent follows from an antecedent in the same cycle.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

FILE: hdl/pfe_pkg.sv
// ----------------------------------------------------------------------------
// pfe_pkg
// Types, codes and small helper functions of the Playfair digram encryptor.
// ----------------------------------------------------------------------------
package pfe_pkg;

  localparam int LETTER_W  = 5;
  localparam int FUNC_W    = 3;
  localparam int RC_W      = 3;
  localparam int ALPHA     = 26;
  localparam int SQ_CELLS  = 25;
  localparam int CFG_IDX_W = 1;

  typedef logic [LETTER_W-1:0] letter_t;
  typedef logic [RC_W-1:0]     rc_t;

  localparam letter_t LETTER_I      = 5'd8;
  localparam letter_t LETTER_J      = 5'd9;
  localparam letter_t LETTER_Q      = 5'd16;
  localparam letter_t LETTER_X      = 5'd23;
  localparam letter_t LETTER_Z      = 5'd25;
  localparam letter_t SQ_FULL_COUNT = 5'd25;

  // Item function codes.
  localparam logic [FUNC_W-1:0] FUNC_KEY   = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_SEAL  = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_PLAIN = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_END   = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 3'd4;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_FILLER     = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ALT_FILLER = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SEAL,
    ST_RD_A,
    ST_RD_B,
    ST_CALC,
    ST_RD_X,
    ST_OUT_X,
    ST_OUT_Y
  } state_t;

  // Out-of-range letters saturate to z, and j folds onto i.
  function automatic letter_t norm_letter(letter_t v);
    letter_t l;
    l = (v > LETTER_Z) ? LETTER_Z : v;
    if (l == LETTER_J) begin
      l = LETTER_I;
    end
    return l;
  endfunction

  function automatic letter_t cell_at(rc_t r, rc_t c);
    return {r[2:0], 2'b00} + {2'b00, r} + {2'b00, c};
  endfunction

  function automatic rc_t pos_row(letter_t p);
    rc_t r;
    if (p >= 5'd20) begin
      r = 3'd4;
    end else if (p >= 5'd15) begin
      r = 3'd3;
    end else if (p >= 5'd10) begin
      r = 3'd2;
    end else if (p >= 5'd5) begin
      r = 3'd1;
    end else begin
      r = 3'd0;
    end
    return r;
  endfunction

  function automatic rc_t pos_col(letter_t p);
    letter_t d;
    d = p - cell_at(pos_row(p), 3'd0);
    return d[RC_W-1:0];
  endfunction

  function automatic rc_t next_rc(rc_t v);
    return (v >= 3'd4) ? 3'd0 : v + 3'd1;
  endfunction

endpackage

FILE: hdl/pfe_ram.sv
// ----------------------------------------------------------------------------
// pfe_ram
// Generic single-write, single-read RAM with a registered read port. The read
// data holds its value while no read is requested.
// ----------------------------------------------------------------------------
module pfe_ram #(
  parameter int WIDTH = 5,
  parameter int DEPTH = 25
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: hdl/playfair_digram_encryptor.sv
// ----------------------------------------------------------------------------
// playfair_digram_encryptor
// Playfair encryptor over a 5x5 key square held in two small RAMs.
// ----------------------------------------------------------------------------
// The block takes one item at a time. A key letter, clear or ignored item
// passes through the execute state and then the input is ready again. A seal
// walks the alphabet one letter a cycle through the letter placement logic.
// A plain letter that completes a digram, or an end of message with a letter
// pending, goes through these steps: the letter-position RAM is read for both
// letters, the target cells are worked out, and the key square RAM is read
// once per cipher letter, all through one read port each. The two cipher
// letters leave through an output register, so a stalled result channel holds
// the block in its output states.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module playfair_digram_encryptor (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [pfe_pkg::FUNC_W-1:0]      in_func,
  input  logic [pfe_pkg::LETTER_W-1:0]    in_letter,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [pfe_pkg::LETTER_W-1:0]    out_cipher_letter,
  output logic                            out_last,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [pfe_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pfe_pkg::LETTER_W-1:0]    cfg_wdata
);

  pfe_pkg::state_t  state_r, state_nxt;
  logic [pfe_pkg::FUNC_W-1:0] func_r;
  pfe_pkg::letter_t letter_r;
  logic             pend_valid_r, pend_valid_nxt;
  pfe_pkg::letter_t pend_letter_r, pend_letter_nxt;
  pfe_pkg::letter_t b_r, b_nxt;
  pfe_pkg::letter_t pa_r, pa_nxt;
  pfe_pkg::letter_t x_idx_r, x_idx_nxt;
  pfe_pkg::letter_t y_idx_r, y_idx_nxt;
  pfe_pkg::letter_t scan_r, scan_nxt;
  pfe_pkg::letter_t count_r, count_nxt;
  logic             sealed_r, sealed_nxt;
  logic [pfe_pkg::ALPHA-1:0] taken_r, taken_nxt;
  pfe_pkg::letter_t filler_r;
  pfe_pkg::letter_t alt_r;
  logic             out_valid_r, out_valid_nxt;
  pfe_pkg::letter_t out_letter_r, out_letter_nxt;
  logic             out_last_r, out_last_nxt;

  logic             in_txn;
  logic             slot_free;
  pfe_pkg::letter_t filler_pick;

  // Shared letter placement unit.
  logic             place_en;
  pfe_pkg::letter_t place_ltr;
  logic             do_place;

  // RAM ports.
  logic             key_re;
  pfe_pkg::letter_t key_raddr;
  pfe_pkg::letter_t key_rdata;
  logic             plc_re;
  pfe_pkg::letter_t plc_raddr;
  pfe_pkg::letter_t plc_rdata;

  // Cell arithmetic for the two letter positions.
  pfe_pkg::rc_t ra, ca, rb, cb;

  // Neither channel takes a transaction while reset is held.
  assign in_ready  = rst_n && (state_r == pfe_pkg::ST_IDLE);
  assign in_txn    = in_valid && in_ready;
  assign cfg_ready = rst_n;
  assign slot_free = !out_valid_r || out_ready;

  assign out_valid         = out_valid_r;
  assign out_cipher_letter = out_letter_r;
  assign out_last          = out_last_r;

  assign do_place = place_en && !taken_r[place_ltr] && (count_r < pfe_pkg::SQ_FULL_COUNT);

  assign ra = pfe_pkg::pos_row(pa_r);
  assign ca = pfe_pkg::pos_col(pa_r);
  assign rb = pfe_pkg::pos_row(plc_rdata);
  assign cb = pfe_pkg::pos_col(plc_rdata);

  always_comb begin
    filler_pick = pfe_pkg::norm_letter(filler_r);
    if (filler_pick == pend_letter_r) begin
      filler_pick = pfe_pkg::norm_letter(alt_r);
    end
  end

  pfe_ram #(.WIDTH(pfe_pkg::LETTER_W), .DEPTH(pfe_pkg::SQ_CELLS)) u_key_ram (
    .clk   (clk),
    .we    (do_place),
    .waddr (count_r),
    .wdata (place_ltr),
    .re    (key_re),
    .raddr (key_raddr),
    .rdata (key_rdata)
  );

  pfe_ram #(.WIDTH(pfe_pkg::LETTER_W), .DEPTH(pfe_pkg::ALPHA)) u_place_ram (
    .clk   (clk),
    .we    (do_place),
    .waddr (place_ltr),
    .wdata (count_r),
    .re    (plc_re),
    .raddr (plc_raddr),
    .rdata (plc_rdata)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pfe_pkg::ST_IDLE: begin
        if (in_txn) begin
          state_nxt = pfe_pkg::ST_EXEC;
        end
      end
      pfe_pkg::ST_EXEC: begin
        state_nxt = pfe_pkg::ST_IDLE;
        priority if (func_r == pfe_pkg::FUNC_SEAL && !sealed_r) begin
          state_nxt = pfe_pkg::ST_SEAL;
        end else if (func_r == pfe_pkg::FUNC_PLAIN && sealed_r && pend_valid_r) begin
          state_nxt = pfe_pkg::ST_RD_A;
        end else if (func_r == pfe_pkg::FUNC_END && sealed_r && pend_valid_r) begin
          state_nxt = pfe_pkg::ST_RD_A;
        end else begin
          state_nxt = pfe_pkg::ST_IDLE;
        end
      end
      pfe_pkg::ST_SEAL: begin
        if (scan_r == pfe_pkg::LETTER_Z) begin
          state_nxt = pfe_pkg::ST_IDLE;
        end
      end
      pfe_pkg::ST_RD_A: state_nxt = pfe_pkg::ST_RD_B;
      pfe_pkg::ST_RD_B: state_nxt = pfe_pkg::ST_CALC;
      pfe_pkg::ST_CALC: state_nxt = pfe_pkg::ST_RD_X;
      pfe_pkg::ST_RD_X: state_nxt = pfe_pkg::ST_OUT_X;
      pfe_pkg::ST_OUT_X: begin
        if (slot_free) begin
          state_nxt = pfe_pkg::ST_OUT_Y;
        end
      end
      pfe_pkg::ST_OUT_Y: begin
        if (slot_free) begin
          state_nxt = pfe_pkg::ST_IDLE;
        end
      end
      default: state_nxt = pfe_pkg::ST_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    pend_valid_nxt  = pend_valid_r;
    pend_letter_nxt = pend_letter_r;
    b_nxt           = b_r;
    pa_nxt          = pa_r;
    x_idx_nxt       = x_idx_r;
    y_idx_nxt       = y_idx_r;
    scan_nxt        = scan_r;
    sealed_nxt      = sealed_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_letter_nxt  = out_letter_r;
    out_last_nxt    = out_last_r;
    place_en        = 1'b0;
    place_ltr       = letter_r;
    key_re          = 1'b0;
    key_raddr       = x_idx_r;
    plc_re          = 1'b0;
    plc_raddr       = pend_letter_r;

    unique case (state_r)
      pfe_pkg::ST_EXEC: begin
        unique case (func_r)
          pfe_pkg::FUNC_KEY: begin
            place_en = !sealed_r;
          end
          pfe_pkg::FUNC_SEAL: begin
            scan_nxt = '0;
          end
          pfe_pkg::FUNC_PLAIN: begin
            if (sealed_r) begin
              if (!pend_valid_r) begin
                pend_valid_nxt  = 1'b1;
                pend_letter_nxt = letter_r;
              end else if (letter_r != pend_letter_r) begin
                pend_valid_nxt = 1'b0;
                b_nxt          = letter_r;
              end else begin
                // Doubled letter: the second copy stays pending.
                b_nxt = filler_pick;
              end
            end
          end
          pfe_pkg::FUNC_END: begin
            if (sealed_r && pend_valid_r) begin
              pend_valid_nxt = 1'b0;
              b_nxt          = filler_pick;
            end
          end
          pfe_pkg::FUNC_CLEAR: begin
            sealed_nxt      = 1'b0;
            pend_valid_nxt  = 1'b0;
            pend_letter_nxt = '0;
          end
          default: begin
          end
        endcase
      end
      pfe_pkg::ST_SEAL: begin
        place_en  = (scan_r != pfe_pkg::LETTER_J);
        place_ltr = scan_r;
        scan_nxt  = scan_r + 5'd1;
        if (scan_r == pfe_pkg::LETTER_Z) begin
          sealed_nxt = 1'b1;
        end
      end
      pfe_pkg::ST_RD_A: begin
        plc_re    = 1'b1;
        plc_raddr = pend_letter_r;
      end
      pfe_pkg::ST_RD_B: begin
        pa_nxt    = plc_rdata;
        plc_re    = 1'b1;
        plc_raddr = b_r;
      end
      pfe_pkg::ST_CALC: begin
        priority if (ca == cb) begin
          x_idx_nxt = pfe_pkg::cell_at(pfe_pkg::next_rc(ra), ca);
          y_idx_nxt = pfe_pkg::cell_at(pfe_pkg::next_rc(rb), cb);
        end else if (ra == rb) begin
          x_idx_nxt = pfe_pkg::cell_at(ra, pfe_pkg::next_rc(ca));
          y_idx_nxt = pfe_pkg::cell_at(rb, pfe_pkg::next_rc(cb));
        end else begin
          x_idx_nxt = pfe_pkg::cell_at(ra, cb);
          y_idx_nxt = pfe_pkg::cell_at(rb, ca);
        end
      end
      pfe_pkg::ST_RD_X: begin
        key_re    = 1'b1;
        key_raddr = x_idx_r;
      end
      pfe_pkg::ST_OUT_X: begin
        if (slot_free) begin
          out_valid_nxt  = 1'b1;
          out_letter_nxt = key_rdata;
          out_last_nxt   = 1'b0;
          key_re         = 1'b1;
          key_raddr      = y_idx_r;
        end
      end
      pfe_pkg::ST_OUT_Y: begin
        if (slot_free) begin
          out_valid_nxt  = 1'b1;
          out_letter_nxt = key_rdata;
          out_last_nxt   = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    taken_nxt = taken_r;
    count_nxt = count_r;
    if (state_r == pfe_pkg::ST_EXEC && func_r == pfe_pkg::FUNC_CLEAR) begin
      taken_nxt = '0;
      count_nxt = '0;
    end else if (do_place) begin
      taken_nxt[place_ltr] = 1'b1;
      count_nxt            = count_r + 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= pfe_pkg::ST_IDLE;
      pend_valid_r  <= 1'b0;
      pend_letter_r <= '0;
      count_r       <= '0;
      sealed_r      <= 1'b0;
      taken_r       <= '0;
      out_valid_r   <= 1'b0;
      filler_r      <= pfe_pkg::LETTER_X;
      alt_r         <= pfe_pkg::LETTER_Q;
    end else begin
      state_r       <= state_nxt;
      pend_valid_r  <= pend_valid_nxt;
      pend_letter_r <= pend_letter_nxt;
      count_r       <= count_nxt;
      sealed_r      <= sealed_nxt;
      taken_r       <= taken_nxt;
      out_valid_r   <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          pfe_pkg::REG_FILLER:     filler_r <= cfg_wdata;
          pfe_pkg::REG_ALT_FILLER: alt_r    <= cfg_wdata;
          default: begin
          end
        endcase
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_txn) begin
      func_r   <= in_func;
      letter_r <= pfe_pkg::norm_letter(in_letter);
    end
    b_r          <= b_nxt;
    pa_r         <= pa_nxt;
    x_idx_r      <= x_idx_nxt;
    y_idx_r      <= y_idx_nxt;
    scan_r       <= scan_nxt;
    out_letter_r <= out_letter_nxt;
    out_last_r   <= out_last_nxt;
  end

  `ASSERT_ALWAYS(a_taken_count, $countones(taken_r) == int'(count_r), "taken count mismatch")
  `ASSERT_IMPL(a_sealed_full, sealed_r, count_r == pfe_pkg::SQ_FULL_COUNT, "sealed but not full")
  `ASSERT_IMPL(a_encrypt_sealed, state_r == pfe_pkg::ST_RD_A, sealed_r, "digram before seal")

endmodule

FILE: tb/playfair_digram_encryptor_test.sv
// ----------------------------------------------------------------------------
// playfair_digram_encryptor_test
// Self-checking testbench for the Playfair digram encryptor. A short table of
// directed transactions covers the default square, ignored items, fillers and
// letter folding. It is followed by random phases of clear, key, seal and
// message traffic with noise mixed in. Typed rows give the expected cipher
// letters, others use a key square model; both channels stall in random bursts.
// ----------------------------------------------------------------------------
module playfair_digram_encryptor_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [pfe_pkg::FUNC_W-1:0] FUNC_UNUSED = 3'd5;
  localparam int ITEM_TARGET   = 1350;
  localparam int QUIET_AFTER   = 1150;
  localparam int SETTLE_CYCLES = 40;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int DIR_ROWS      = 28;

  typedef struct packed {
    pfe_pkg::letter_t cipher_letter;
    logic             last;
  } cipher_out_t;

  typedef struct packed {
    logic [pfe_pkg::FUNC_W-1:0] func;
    pfe_pkg::letter_t           letter;
    logic                       typed;
    logic                       has_pair;
    pfe_pkg::letter_t           want0;
    pfe_pkg::letter_t           want1;
  } stim_row_t;

  logic                          clk;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_ready;
  logic [pfe_pkg::FUNC_W-1:0]    in_func;
  pfe_pkg::letter_t              in_letter;
  logic                          out_valid;
  logic                          out_ready;
  pfe_pkg::letter_t              out_cipher_letter;
  logic                          out_last;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [pfe_pkg::CFG_IDX_W-1:0] cfg_index;
  pfe_pkg::letter_t              cfg_wdata;

  // Model state of the key square and the message.
  pfe_pkg::letter_t sq_cell [pfe_pkg::SQ_CELLS];
  pfe_pkg::letter_t sq_place [pfe_pkg::ALPHA];
  bit               sq_taken [pfe_pkg::ALPHA];
  int               sq_count;
  bit               sq_sealed;
  bit               pend_valid;
  pfe_pkg::letter_t pend_letter;
  pfe_pkg::letter_t fill_cfg;
  pfe_pkg::letter_t alt_cfg;

  cipher_out_t cipher_q[$];
  cipher_out_t got_exp;
  int          mismatches;
  int          items_sent;
  int          stall_left;
  int          cycle_count;
  bit          idle_on;

  // Default square after reset: abcde fghik lmnop qrstu vwxyz, fillers x and q.
  stim_row_t dir_rows [DIR_ROWS] = '{
    '{pfe_pkg::FUNC_PLAIN, 5'd0,  1'b1, 1'b0, 5'd0,  5'd0},
    '{pfe_pkg::FUNC_END,   5'd0,  1'b1, 1'b0, 5'd0,  5'd0},
    '{FUNC_UNUSED,         5'd0,  1'b1, 1'b0, 5'd0,  5'd0},
    '{pfe_pkg::FUNC_SEAL,  5'd0,  1'b1, 1'b0, 5'd0,  5'd0},
    '{pfe_pkg::FUNC_SEAL,  5'd0,  1'b1, 1'b0, 5'd0,  5'd0},
    '{pfe_pkg::FUNC_KEY,   5'd10, 1'b1, 1'b0, 5'd0,  5'd0},
    '{pfe_pkg::FUNC_PLAIN, 5'd0,  1'b1, 1'b0, 5'd0,  5'd0},
    '{pfe_pkg::FUNC_PLAIN, 5'd1,  1'b1, 1'b1, 5'd1,  5'd2},
    '{pfe_pkg::FUNC_PLAIN, 5'd0,  1'b1, 1'b0, 5'd0,  5'd0},
    '{pfe_pkg::FUNC_PLAIN, 5'd25, 1'b1, 1'b1, 5'd4,  5'd21},
    '{pfe_pkg::FUNC_PLAIN, 5'd0,  1'b1, 1'b0, 5'd0,  5'd0},
    '{pfe_pkg::FUNC_PLAIN, 5'd5,  1'b1, 1'b1, 5'd5,  5'd11},
    '{pfe_pkg::FUNC_END,   5'd0,  1'b1, 1'b0, 5'd0,  5'd0},
    '{pfe_pkg::FUNC_PLAIN, 5'd9,  1'b1, 1'b0, 5'd0,  5'd0},
    '{pfe_pkg::FUNC_PLAIN, 5'd8,  1'b1, 1'b1, 5'd7,  5'd24},
    '{pfe_pkg::FUNC_END,   5'd0,  1'b1, 1'b1, 5'd7,  5'd24},
    '{pfe_pkg::FUNC_PLAIN, 5'd23, 1'b1, 1'b0, 5'd0,  5'd0},
    '{pfe_pkg::FUNC_END,   5'd0,  1'b1, 1'b1, 5'd21, 5'd18},
    '{pfe_pkg::FUNC_CLEAR, 5'd0,  1'b1, 1'b0, 5'd0,  5'd0},
    '{pfe_pkg::FUNC_PLAIN, 5'd0,  1'b1, 1'b0, 5'd0,  5'd0},
    '{pfe_pkg::FUNC_KEY,   5'd9,  1'b0, 1'b0, 5'd0,  5'd0},
    '{pfe_pkg::FUNC_KEY,   5'd31, 1'b0, 1'b0, 5'd0,  5'd0},
    '{pfe_pkg::FUNC_KEY,   5'd25, 1'b0, 1'b0, 5'd0,  5'd0},
    '{pfe_pkg::FUNC_KEY,   5'd4,  1'b0, 1'b0, 5'd0,  5'd0},
    '{pfe_pkg::FUNC_SEAL,  5'd0,  1'b0, 1'b0, 5'd0,  5'd0},
    '{pfe_pkg::FUNC_PLAIN, 5'd8,  1'b0, 1'b0, 5'd0,  5'd0},
    '{pfe_pkg::FUNC_PLAIN, 5'd25, 1'b0, 1'b0, 5'd0,  5'd0},
    '{pfe_pkg::FUNC_END,   5'd0,  1'b0, 1'b0, 5'd0,  5'd0}
  };

  playfair_digram_encryptor dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_func           (in_func),
    .in_letter         (in_letter),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_cipher_letter (out_cipher_letter),
    .out_last          (out_last),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic pfe_pkg::letter_t fold_letter(pfe_pkg::letter_t raw);
    pfe_pkg::letter_t v;
    v = (raw > pfe_pkg::LETTER_Z) ? pfe_pkg::LETTER_Z : raw;
    if (v == pfe_pkg::LETTER_J) begin
      v = pfe_pkg::LETTER_I;
    end
    return v;
  endfunction

  function automatic bit place_key(pfe_pkg::letter_t l);
    if (sq_taken[l] || sq_count >= pfe_pkg::SQ_CELLS) begin
      return 1'b0;
    end
    sq_taken[l] = 1'b1;
    sq_cell[sq_count] = l;
    sq_place[l] = pfe_pkg::letter_t'(sq_count);
    sq_count++;
    return 1'b1;
  endfunction

  function automatic void clear_square();
    for (int k = 0; k < pfe_pkg::ALPHA; k++) begin
      sq_taken[k] = 1'b0;
    end
    sq_count = 0;
    sq_sealed = 1'b0;
    pend_valid = 1'b0;
    pend_letter = '0;
  endfunction

  function automatic void cipher_pair(pfe_pkg::letter_t a, pfe_pkg::letter_t b,
                                      output pfe_pkg::letter_t r0,
                                      output pfe_pkg::letter_t r1);
    int pa, pb, ra, ca, rb, cb;
    pa = int'(sq_place[a]);
    pb = int'(sq_place[b]);
    ra = pa / 5;
    ca = pa % 5;
    rb = pb / 5;
    cb = pb % 5;
    if (ca == cb) begin
      r0 = sq_cell[((ra + 1) % 5) * 5 + ca];
      r1 = sq_cell[((rb + 1) % 5) * 5 + cb];
    end else if (ra == rb) begin
      r0 = sq_cell[ra * 5 + (ca + 1) % 5];
      r1 = sq_cell[rb * 5 + (cb + 1) % 5];
    end else begin
      r0 = sq_cell[ra * 5 + cb];
      r1 = sq_cell[rb * 5 + ca];
    end
  endfunction

  function automatic pfe_pkg::letter_t pad_for(pfe_pkg::letter_t a);
    pfe_pkg::letter_t f;
    f = fold_letter(fill_cfg);
    if (f == a) begin
      f = fold_letter(alt_cfg);
    end
    return f;
  endfunction

  // Appends one expected cipher letter at the tail of the queue.
  function automatic void expect_letter(pfe_pkg::letter_t l, logic last);
    cipher_out_t v;
    v.cipher_letter = l;
    v.last = last;
    cipher_q.insert(cipher_q.size(), v);
  endfunction

  // Advances the model by one transaction. Returns whether the item changed
  // anything; n gives the number of cipher letters it produces.
  function automatic bit predict_item(logic [pfe_pkg::FUNC_W-1:0] f, pfe_pkg::letter_t raw,
                                      output int n, output pfe_pkg::letter_t r0,
                                      output pfe_pkg::letter_t r1);
    pfe_pkg::letter_t l;
    bit               eff;
    l = fold_letter(raw);
    n = 0;
    r0 = '0;
    r1 = '0;
    eff = 1'b0;
    case (f)
      pfe_pkg::FUNC_KEY: begin
        if (!sq_sealed) begin
          eff = place_key(l);
        end
      end
      pfe_pkg::FUNC_SEAL: begin
        if (!sq_sealed) begin
          for (int k = 0; k < pfe_pkg::ALPHA; k++) begin
            if (pfe_pkg::letter_t'(k) != pfe_pkg::LETTER_J) begin
              void'(place_key(pfe_pkg::letter_t'(k)));
            end
          end
          sq_sealed = 1'b1;
          eff = 1'b1;
        end
      end
      pfe_pkg::FUNC_PLAIN: begin
        if (sq_sealed) begin
          eff = 1'b1;
          if (!pend_valid) begin
            pend_valid = 1'b1;
            pend_letter = l;
          end else if (l != pend_letter) begin
            pend_valid = 1'b0;
            cipher_pair(pend_letter, l, r0, r1);
            n = 2;
          end else begin
            // The first of a doubled letter goes out with the filler and the
            // second one stays pending.
            cipher_pair(pend_letter, pad_for(pend_letter), r0, r1);
            n = 2;
          end
        end
      end
      pfe_pkg::FUNC_END: begin
        if (sq_sealed && pend_valid) begin
          eff = 1'b1;
          pend_valid = 1'b0;
          cipher_pair(pend_letter, pad_for(pend_letter), r0, r1);
          n = 2;
        end
      end
      pfe_pkg::FUNC_CLEAR: begin
        clear_square();
        eff = 1'b1;
      end
      default: begin
      end
    endcase
    return eff;
  endfunction

  task automatic send_item(input logic [pfe_pkg::FUNC_W-1:0] f, input pfe_pkg::letter_t l,
                           input bit typed, input bit t_has, input pfe_pkg::letter_t t0,
                           input pfe_pkg::letter_t t1);
    int               n;
    pfe_pkg::letter_t p0, p1;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_func   <= f;
    in_letter <= l;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    void'(predict_item(f, l, n, p0, p1));
    if (typed) begin
      if (t_has) begin
        expect_letter(t0, 1'b0);
        expect_letter(t1, 1'b1);
      end
    end else if (n == 2) begin
      expect_letter(p0, 1'b0);
      expect_letter(p1, 1'b1);
    end
  endtask

  task automatic send_noise();
    send_item(3'($urandom_range(0, 7)), 5'($urandom_range(0, 31)), 1'b0, 1'b0, '0, '0);
  endtask

  // Waits until every cipher letter has come out, then for the longest
  // internal operation that produces no output.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (cipher_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [pfe_pkg::CFG_IDX_W-1:0] idx,
                           input pfe_pkg::letter_t data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == pfe_pkg::REG_FILLER) begin
      fill_cfg = data;
    end else begin
      alt_cfg = data;
    end
  endtask

  task automatic set_fillers(input pfe_pkg::letter_t f, input pfe_pkg::letter_t a);
    wait_idle();
    if ($urandom_range(0, 1) == 0) begin
      write_reg(pfe_pkg::REG_FILLER, f);
      write_reg(pfe_pkg::REG_ALT_FILLER, a);
    end else begin
      write_reg(pfe_pkg::REG_ALT_FILLER, a);
      write_reg(pfe_pkg::REG_FILLER, f);
    end
    cfg_valid <= 1'b0;
  endtask

  function automatic pfe_pkg::letter_t pick_filler();
    case ($urandom_range(0, 5))
      0:       return 5'd0;
      1:       return pfe_pkg::LETTER_Z;
      2:       return 5'd31;
      3:       return pfe_pkg::LETTER_J;
      default: return 5'($urandom_range(0, 31));
    endcase
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (cipher_q.size() == 0) begin
          if (mismatches < 10) begin
            $display("unexpected cipher letter %0d last %0d", out_cipher_letter, out_last);
          end
          mismatches++;
        end else begin
          got_exp = cipher_q.pop_front();
          if (out_cipher_letter !== got_exp.cipher_letter || out_last !== got_exp.last) begin
            if (mismatches < 10) begin
              $display("mismatch: expected letter %0d last %0d, got letter %0d last %0d",
                       got_exp.cipher_letter, got_exp.last, out_cipher_letter, out_last);
            end
            mismatches++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 19) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    pfe_pkg::letter_t early_fill [4];
    pfe_pkg::letter_t early_alt [4];
    pfe_pkg::letter_t fv, av, prev, cur;
    int               phase, len, r;
    early_fill = '{5'd0, 5'd31, pfe_pkg::LETTER_J, pfe_pkg::LETTER_Z};
    early_alt  = '{5'd31, pfe_pkg::LETTER_Z, pfe_pkg::LETTER_I, 5'd0};
    cycle_count = 0;
    mismatches = 0;
    items_sent = 0;
    stall_left = 0;
    idle_on = 1'b1;
    clear_square();
    fill_cfg = pfe_pkg::LETTER_X;
    alt_cfg = pfe_pkg::LETTER_Q;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_func   <= pfe_pkg::FUNC_KEY;
    in_letter <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= pfe_pkg::REG_FILLER;
    cfg_wdata <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int row = 0; row < DIR_ROWS; row++) begin
      send_item(dir_rows[row].func, dir_rows[row].letter, dir_rows[row].typed,
                dir_rows[row].has_pair, dir_rows[row].want0, dir_rows[row].want1);
    end

    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      if (items_sent >= QUIET_AFTER) begin
        idle_on = 1'b0;
      end
      if (phase < 4) begin
        set_fillers(early_fill[phase], early_alt[phase]);
      end else begin
        fv = pick_filler();
        av = ($urandom_range(0, 3) == 0) ? fv : pick_filler();
        set_fillers(fv, av);
      end
      if ($urandom_range(0, 7) != 0) begin
        // A whole message: fresh key, seal, then plaintext with some doubled
        // letters, early ends and stray transactions.
        send_item(pfe_pkg::FUNC_CLEAR, 5'($urandom_range(0, 31)), 1'b0, 1'b0, '0, '0);
        len = $urandom_range(0, 36);
        for (int k = 0; k < len; k++) begin
          if ($urandom_range(0, 19) == 0) begin
            send_noise();
          end
          send_item(pfe_pkg::FUNC_KEY, 5'($urandom_range(0, 31)), 1'b0, 1'b0, '0, '0);
        end
        send_item(pfe_pkg::FUNC_SEAL, 5'($urandom_range(0, 31)), 1'b0, 1'b0, '0, '0);
        len = $urandom_range(4, 60);
        prev = 5'($urandom_range(0, 31));
        for (int k = 0; k < len; k++) begin
          r = $urandom_range(0, 19);
          if (r == 0) begin
            send_noise();
          end else if (r < 3) begin
            send_item(pfe_pkg::FUNC_END, 5'($urandom_range(0, 31)), 1'b0, 1'b0, '0, '0);
          end else begin
            cur = (r < 7) ? prev : 5'($urandom_range(0, 31));
            send_item(pfe_pkg::FUNC_PLAIN, cur, 1'b0, 1'b0, '0, '0);
            prev = cur;
          end
        end
        send_item(pfe_pkg::FUNC_END, 5'($urandom_range(0, 31)), 1'b0, 1'b0, '0, '0);
      end else begin
        len = $urandom_range(5, 20);
        for (int k = 0; k < len; k++) begin
          send_noise();
        end
      end
      phase++;
    end

    wait_idle();
    if (mismatches == 0 && cipher_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
